FILE: rtl/extended_euclid_bezout_assert.svh
// Assertion macros for the block's top-level module.
`ifndef EXTENDED_EUCLID_BEZOUT_ASSERT_SVH
`define EXTENDED_EUCLID_BEZOUT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EEB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define EEB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/eeb_pkg.sv
`timescale 1ns / 1ps

package eeb_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int CNT_W      = $clog2(WORD_WIDTH);

  typedef logic [WORD_WIDTH-1:0] word_t;

  // one quotient bit, MSB first, from the divider
  typedef struct packed {
    logic valid;
    logic qb;
    logic last;
  } qbit_t;

  // control from the sequencer to a coefficient unit
  typedef struct packed {
    logic init;
    logic clear;
    logic acc;
    logic qb;
    logic update;
  } coef_ctl_t;

endpackage

FILE: rtl/eeb_divider.sv
`timescale 1ns / 1ps

module eeb_divider import eeb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output qbit_t qbit,
  output word_t remainder
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ALIGN = 2'd1;
  localparam logic [1:0] PH_SUB   = 2'd2;

  logic [1:0]       phase;
  word_t            rem;
  word_t            dv;
  logic [CNT_W-1:0] cnt;

  logic                can_shift;
  logic                ge;
  logic [WORD_WIDTH:0] dv_dbl;

  // divisor may move up one place if it stays within the word and does not exceed rem
  assign dv_dbl    = {dv, 1'b0};
  assign can_shift = !dv[WORD_WIDTH-1] && (dv_dbl <= {1'b0, rem});
  assign ge        = (rem >= dv);

  always_comb begin
    qbit.valid = (phase == PH_SUB);
    qbit.qb    = ge;
    qbit.last  = (cnt == '0);
  end

  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_ALIGN;
          end
        end
        PH_ALIGN: begin
          if (!can_shift) begin
            phase <= PH_SUB;
          end
        end
        PH_SUB: begin
          if (cnt == '0) begin
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dv  <= divisor;
      cnt <= '0;
    end else if (phase == PH_ALIGN) begin
      if (can_shift) begin
        dv  <= dv_dbl[WORD_WIDTH-1:0];
        cnt <= cnt + 1'b1;
      end
    end else if (phase == PH_SUB) begin
      if (ge) begin
        rem <= rem - dv;
      end
      if (cnt != '0) begin
        dv  <= {1'b0, dv[WORD_WIDTH-1:1]};
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/eeb_coef.sv
`timescale 1ns / 1ps

module eeb_coef import eeb_pkg::*; (
  input  logic      clk,
  input  coef_ctl_t ctl,
  input  word_t     init_a,
  input  word_t     init_b,
  output word_t     coef
);

  word_t cur_a;   // coefficient of the dividend
  word_t cur_b;   // coefficient of the divisor
  word_t prod;    // cur_b * quotient, built MSB first

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      cur_a <= init_a;
      cur_b <= init_b;
    end else if (ctl.update) begin
      cur_a <= cur_b;
      cur_b <= cur_a - prod;
    end
    if (ctl.clear) begin
      prod <= '0;
    end else if (ctl.acc) begin
      prod <= {prod[WORD_WIDTH-2:0], 1'b0} + (ctl.qb ? cur_b : '0);
    end
  end

  assign coef = cur_a;

endmodule

FILE: rtl/extended_euclid_bezout.sv
`timescale 1ns / 1ps
// Extended Euclid: gcd and Bezout coefficients of two unsigned words.
// Each division step loads the divider, shifts the divisor up to align it, subtracts
// while streaming quotient bits MSB first, then updates remainders and coefficients.
// One item at a time: a new input is taken only after the last result reaches the output register.
// Reset (rst, synchronous) clears the sequencer and output valid; data registers keep values.

module extended_euclid_bezout import eeb_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [WORD_WIDTH-1:0] a_value,
  input  logic        [WORD_WIDTH-1:0] b_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [WORD_WIDTH-1:0] gcd_value,
  output logic signed [WORD_WIDTH-1:0] coef_a,
  output logic signed [WORD_WIDTH-1:0] coef_b
);

`include "extended_euclid_bezout_assert.svh"

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an input transfer
  localparam logic [2:0] ST_LOAD = 3'd1;  // start divider, clear products
  localparam logic [2:0] ST_DIV  = 3'd2;  // quotient bits stream out
  localparam logic [2:0] ST_UPD  = 3'd3;  // shift remainders and coefficients
  localparam logic [2:0] ST_FIN  = 3'd4;  // hand result to output register

  localparam word_t ONE  = word_t'(1);
  localparam word_t ZERO = '0;

  logic [2:0] state;
  word_t      rem_hi;   // current dividend
  word_t      rem_lo;   // current divisor

  qbit_t      qbit;
  word_t      div_rem;
  coef_ctl_t  cctl;
  word_t      x_coef;
  word_t      y_coef;

  logic in_xfer;
  logic out_load;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  // output register is free or drains this cycle
  assign out_load = (state == ST_FIN) && (!out_valid || out_ready);

  always_comb begin
    cctl.init   = in_xfer;
    cctl.clear  = (state == ST_LOAD);
    cctl.acc    = qbit.valid;
    cctl.qb     = qbit.qb;
    cctl.update = (state == ST_UPD);
  end

  // shift-subtract divider, one quotient bit per cycle once the divisor is aligned
  eeb_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ST_LOAD),
    .dividend  (rem_hi),
    .divisor   (rem_lo),
    .qbit      (qbit),
    .remainder (div_rem)
  );

  // coefficient of a: starts (1, 0)
  eeb_coef u_coef_x (
    .clk    (clk),
    .ctl    (cctl),
    .init_a (ONE),
    .init_b (ZERO),
    .coef   (x_coef)
  );

  // coefficient of b: starts (0, 1)
  eeb_coef u_coef_y (
    .clk    (clk),
    .ctl    (cctl),
    .init_a (ZERO),
    .init_b (ONE),
    .coef   (y_coef)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drained with no new result behind it
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            // zero divisor: result is (a, 1, 0) straight away
            state <= (b_value == '0) ? ST_FIN : ST_LOAD;
          end
        end
        ST_LOAD: state <= ST_DIV;
        ST_DIV: begin
          if (qbit.valid && qbit.last) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: state <= (div_rem == '0) ? ST_FIN : ST_LOAD;
        ST_FIN: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rem_hi <= a_value;
      rem_lo <= b_value;
    end else if (state == ST_UPD) begin
      rem_hi <= rem_lo;
      rem_lo <= div_rem;
    end
    if (out_load) begin
      gcd_value <= rem_hi;
      coef_a    <= $signed(x_coef);
      coef_b    <= $signed(y_coef);
    end
  end

  `EEB_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_xfer, (state == ST_LOAD) || (state == ST_FIN), "accepted transfer did not start work")
  `EEB_ASSERT_NOW(a_qbit_in_div, clk, rst, qbit.valid, state == ST_DIV, "quotient bit outside divide state")
  `EEB_ASSERT_NOW(a_divisor_nonzero, clk, rst, (state == ST_UPD) || (state == ST_LOAD), rem_lo != '0, "division step with zero divisor")
  `EEB_ASSERT_NEXT(a_fin_loads_out, clk, rst, out_load, out_valid && (state == ST_IDLE), "result not registered")

endmodule

FILE: sim/tb_extended_euclid_bezout.sv
`timescale 1ns / 1ps

module tb_extended_euclid_bezout;
  import eeb_pkg::*;

  // one operand pair as offered to the block
  typedef struct packed {
    word_t a;
    word_t b;
  } operand_pair_t;

  // gcd and Bezout coefficients as the block should return them
  typedef struct packed {
    word_t                         gcd;
    logic signed [WORD_WIDTH-1:0]  x;
    logic signed [WORD_WIDTH-1:0]  y;
  } bezout_t;

  localparam int RANDOM_PAIRS = 1930;
  localparam int DRAIN_CYCLES = 400;  // longer than the worst single-item latency

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  word_t                        a_value = '0;
  word_t                        b_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  word_t                        gcd_value;
  logic signed [WORD_WIDTH-1:0] coef_a;
  logic signed [WORD_WIDTH-1:0] coef_b;

  operand_pair_t operand_q[$];  // pairs not yet offered
  bezout_t       bezout_q[$];   // results owed by the block, oldest first

  int   errors = 0;
  int   results_seen = 0;
  bit   in_taken = 1'b0;        // input transfer at the last rising edge
  int   stall_left = 0;
  bit   first_holdoff = 1'b0;
  bit   second_holdoff = 1'b0;
  logic quiet_phase;
  word_t fib[0:47];

  extended_euclid_bezout uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_value   (a_value),
    .b_value   (b_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gcd_value (gcd_value),
    .coef_a    (coef_a),
    .coef_b    (coef_b)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Neither side idles during this window, so back-to-back transfers get exercised.
  assign quiet_phase = (results_seen >= 600) && (results_seen < 1100);

  // Extended Euclid with all coefficient math in word-width wraparound.
  // Only the low WORD_WIDTH bits of xb*q matter, so a plain word multiply suffices.
  function automatic bezout_t solve_bezout(word_t a, word_t b);
    word_t   hi, lo, q, r, xa, ya, xb, yb, nx, ny;
    bezout_t res;
    hi = a;
    lo = b;
    xa = 1;
    ya = 0;
    xb = 0;
    yb = 1;
    while (lo != 0) begin
      q  = hi / lo;
      r  = hi % lo;
      nx = xa - xb * q;
      ny = ya - yb * q;
      hi = lo;
      lo = r;
      xa = xb;
      ya = yb;
      xb = nx;
      yb = ny;
    end
    res.gcd = hi;
    res.x   = xa;
    res.y   = ya;
    return res;
  endfunction

  task automatic queue_pair(word_t a, word_t b);
    operand_pair_t p;
    p.a = a;
    p.b = b;
    operand_q.push_back(p);
  endtask

  // Random pair, weighted toward shapes that stress the step count and the divider.
  task automatic queue_random_pair();
    word_t g, u, v;
    int    kind, idx;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // full-range operands: every bit toggles
      queue_pair($urandom, $urandom);
    end else if (kind < 55) begin
      // shared factor so the gcd is not 1
      g = $urandom_range(2, 65535);
      u = $urandom_range(0, 32'hFFFF_FFFF / g);
      v = $urandom_range(0, 32'hFFFF_FFFF / g);
      queue_pair(g * u, g * v);
    end else if (kind < 67) begin
      queue_pair($urandom_range(0, 255), $urandom_range(0, 255));
    end else if (kind < 77) begin
      // consecutive Fibonacci: longest chains of unit quotients
      idx = $urandom_range(2, 47);
      if ($urandom_range(1))
        queue_pair(fib[idx], fib[idx-1]);
      else
        queue_pair(fib[idx-1], fib[idx]);
    end else if (kind < 87) begin
      // big dividend over a tiny divisor: long quotients, many align shifts
      queue_pair($urandom | 32'h8000_0000, $urandom_range(1, 15));
    end else begin
      case ($urandom_range(4))
        0:       queue_pair($urandom, 0);
        1:       queue_pair(0, $urandom);
        2: begin
          g = $urandom;
          queue_pair(g, g);
        end
        3:       queue_pair($urandom_range(1, 15), $urandom | 32'h8000_0000);
        default: queue_pair($urandom >> $urandom_range(31), $urandom >> $urandom_range(31));
      endcase
    end
  endtask

  // Sender: inputs move on the falling edge. A pending transfer holds until taken.
  always @(negedge clk) begin : drive_operands
    operand_pair_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // waiting for in_ready, payload stays put
    end else if (operand_q.size() != 0 && (quiet_phase || $urandom_range(99) >= 7)) begin
      nxt = operand_q.pop_front();
      in_valid <= 1'b1;
      a_value  <= nxt.a;
      b_value  <= nxt.b;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random 7% stalls, plus two long hold-offs that back the block
  // up while the sender keeps offering.
  always @(negedge clk) begin : drive_out_ready
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!first_holdoff && results_seen >= 100) begin
      first_holdoff = 1'b1;
      stall_left = 500;
      out_ready <= 1'b0;
    end else if (!second_holdoff && results_seen >= 1400) begin
      second_holdoff = 1'b1;
      stall_left = 350;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_phase || ($urandom_range(99) >= 7);
    end
  end

  // Monitor: sample both handshakes on the rising edge. Check the output side
  // first so a stray result is never matched to a pair taken in the same cycle.
  always @(posedge clk) begin : check_results
    bezout_t want;
    in_taken = in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        results_seen = results_seen + 1;
        if (bezout_q.size() == 0) begin
          $error("result transfer with nothing outstanding: gcd %0d", gcd_value);
          errors = errors + 1;
        end else begin
          want = bezout_q.pop_front();
          if (gcd_value !== want.gcd) begin
            $error("gcd_value mismatch: expected %0d, got %0d", want.gcd, gcd_value);
            errors = errors + 1;
          end
          if (coef_a !== want.x) begin
            $error("coef_a mismatch: expected %0d, got %0d", want.x, coef_a);
            errors = errors + 1;
          end
          if (coef_b !== want.y) begin
            $error("coef_b mismatch: expected %0d, got %0d", want.y, coef_b);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && in_ready)
        bezout_q.push_back(solve_bezout(a_value, b_value));
    end
  end

  initial begin : stimulus
    int i;
    fib[0] = 0;
    fib[1] = 1;
    for (i = 2; i < 48; i++)
      fib[i] = fib[i-1] + fib[i-2];

    // Directed: zero operands, extremes, worst chains, wrapping coefficients.
    queue_pair(0, 0);
    queue_pair(12345, 0);
    queue_pair(0, 6789);
    queue_pair(32'hFFFF_FFFF, 0);
    queue_pair(0, 32'hFFFF_FFFF);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pair(32'hFFFF_FFFF, 1);
    queue_pair(1, 32'hFFFF_FFFF);
    queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    queue_pair(32'h8000_0000, 1);
    queue_pair(32'h8000_0000, 32'h4000_0000);
    queue_pair(32'h8000_0001, 32'h8000_0000);   // coefficient hits 2^31, wraps
    queue_pair(2, 32'hFFFF_FFFF);
    queue_pair(fib[47], fib[46]);
    queue_pair(fib[46], fib[47]);
    queue_pair(1, 1);
    queue_pair(240, 46);
    queue_pair(46, 240);
    queue_pair(32'hFFFF_FFFB, 32'h7FFF_FFFF);
    queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
    queue_pair(32'h5555_5555, 32'hAAAA_AAAA);

    for (i = 0; i < RANDOM_PAIRS; i++)
      queue_random_pair();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // all pairs offered and taken, then every owed result back
    while (operand_q.size() != 0 || in_valid)
      @(posedge clk);
    while (bezout_q.size() != 0)
      @(posedge clk);
    // a late stray result would still be flagged by the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog: allows several times the worst-case run time before declaring FAIL.
  initial begin : watchdog
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/eeb_pkg.sv
rtl/eeb_divider.sv
rtl/eeb_coef.sv
rtl/extended_euclid_bezout.sv
sim/tb_extended_euclid_bezout.sv
